@@ rtl/puf_pkg.sv @@
package puf_pkg;
  localparam int NODES = 1024;
  localparam int TIME_BITS = 30;
  localparam int NODE_BITS = $clog2(NODES);
  localparam int SIZE_BITS = NODE_BITS + 1;
  localparam int JOIN_BITS = TIME_BITS + 1;
  localparam int QDEPTH = 2;
  localparam int QPTR_BITS = 1;

  typedef enum logic [1:0] {
    ACT_UNITE = 2'd0,
    ACT_CONN  = 2'd1,
    ACT_TIME  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_TRIVIAL = 2'd0,
    KIND_UNITE   = 2'd1,
    KIND_CONN    = 2'd2,
    KIND_TIME    = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                 kind;
    logic                  flag;
    logic [NODE_BITS-1:0]  a;
    logic [NODE_BITS-1:0]  b;
    logic [TIME_BITS-1:0]  stamp;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A,
    ST_WT_A,
    ST_CL_A,
    ST_RD_B,
    ST_WT_B,
    ST_CL_B,
    ST_UNITE,
    ST_UPD,
    ST_RD_P,
    ST_WT_P,
    ST_PM,
    ST_OUT
  } state_e;
endpackage

@@ rtl/puf_front.sv @@
module puf_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 action_i,
  input  logic [puf_pkg::NODE_BITS-1:0] node_a_i,
  input  logic [puf_pkg::NODE_BITS-1:0] node_b_i,
  input  logic [puf_pkg::TIME_BITS-1:0] stamp_i,
  output logic                       job_valid_o,
  input  logic                       job_ready_i,
  output puf_pkg::job_t              job_o
);
  import puf_pkg::*;

  job_t                 q_mem [QDEPTH];
  logic [QPTR_BITS-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QPTR_BITS:0]   cnt_q, cnt_d;
  job_t                 cls;
  logic                 push, pop;

  always_comb begin
    cls.a = node_a_i;
    cls.b = node_b_i;
    cls.stamp = stamp_i;
    cls.flag = 1'b0;
    cls.kind = KIND_TRIVIAL;
    case (action_e'(action_i))
      ACT_UNITE: if (node_a_i != node_b_i) cls.kind = KIND_UNITE;
      ACT_CONN: begin
        if (node_a_i == node_b_i) cls.flag = 1'b1;
        else cls.kind = KIND_CONN;
      end
      ACT_TIME: begin
        if (node_a_i == node_b_i) cls.flag = 1'b1;
        else cls.kind = KIND_TIME;
      end
      default: cls.kind = KIND_TRIVIAL;
    endcase
  end

  assign in_ready_o = (cnt_q != (QPTR_BITS+1)'(QDEPTH));
  assign push = in_valid_i && in_ready_o;
  assign job_valid_o = (cnt_q != '0);
  assign pop = job_valid_o && job_ready_i;
  assign job_o = q_mem[rd_q];

  always_comb begin
    wr_d = push ? wr_q + 1'b1 : wr_q;
    rd_d = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QPTR_BITS+1)'(QDEPTH)) else $error("queue overflow");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("queue count");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == (QPTR_BITS+1)'(QDEPTH) |-> !push) else $error("push on full");
endmodule

@@ rtl/puf_back.sv @@
module puf_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  output logic                          job_ready_o,
  input  puf_pkg::job_t                 job_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          flag_o,
  output logic [puf_pkg::TIME_BITS-1:0] join_stamp_o
);
  import puf_pkg::*;

  // Memories hold the stored value xor'ed with the reset value, so all-zero
  // entries from the clearing pass mean reset. parent stored as p ^ idx,
  // size as s - 1, join as j ^ NEVER.
  logic [NODE_BITS-1:0] par_mem [NODES];
  logic [NODE_BITS-1:0] siz_mem [NODES];
  logic [JOIN_BITS-1:0] jn_mem  [NODES];
  localparam logic [JOIN_BITS-1:0] NEVER = {1'b1, {TIME_BITS{1'b0}}};

  state_e st_q, st_d;
  job_t   job_q;
  logic   clr_q;
  logic [NODE_BITS:0] clr_cnt_q;

  logic [NODE_BITS-1:0] rd_addr, rd_addr2;
  logic [NODE_BITS-1:0] rpar_q, rsiz_q;
  logic [JOIN_BITS-1:0] rjn_q;
  logic [NODE_BITS-1:0] rpar2_q;
  logic [JOIN_BITS-1:0] rjn2_q;
  logic [NODE_BITS-1:0] raddr_q, raddr2_q;

  logic [NODE_BITS-1:0] cur_q, cur_d, ra_q, ra_d, rb_q, rb_d;
  logic [NODE_BITS:0]   dep_q, dep_d, da_q, da_d;
  logic [NODE_BITS-1:0] sza_q, sza_d, szb_q, szb_d;
  logic [NODE_BITS-1:0] pa_q, pa_d, pb_q, pb_d;
  logic [NODE_BITS:0]   db_q, db_d;
  logic [JOIN_BITS-1:0] best_q, best_d;
  logic                 flag_q, flag_d;
  logic [TIME_BITS-1:0] when_q, when_d;
  logic                 ov_q;

  logic [NODE_BITS-1:0] par_v, par2_v;
  logic [JOIN_BITS-1:0] jn_v, jn2_v;
  logic                 stop_v;
  logic                 wr_en;
  logic [NODE_BITS-1:0] wr_addr, wr_par, wr_siz_addr, wr_siz;
  logic                 wr_siz_en;
  logic [JOIN_BITS-1:0] wr_jn;
  logic                 take;

  assign par_v  = rpar_q ^ raddr_q;
  assign jn_v   = rjn_q ^ NEVER;
  assign par2_v = rpar2_q ^ raddr2_q;
  assign jn2_v  = rjn2_q ^ NEVER;

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      par_mem[clr_cnt_q[NODE_BITS-1:0]] <= '0;
      siz_mem[clr_cnt_q[NODE_BITS-1:0]] <= '0;
      jn_mem[clr_cnt_q[NODE_BITS-1:0]]  <= '0;
    end else begin
      if (wr_en) begin
        par_mem[wr_addr] <= wr_par ^ wr_addr;
        jn_mem[wr_addr]  <= wr_jn ^ NEVER;
      end
      if (wr_siz_en) siz_mem[wr_siz_addr] <= wr_siz;
    end
    rpar_q <= par_mem[rd_addr];
    rsiz_q <= siz_mem[rd_addr];
    rjn_q  <= jn_mem[rd_addr];
    raddr_q <= rd_addr;
    rpar2_q <= par_mem[rd_addr2];
    rjn2_q  <= jn_mem[rd_addr2];
    raddr2_q <= rd_addr2;
  end

  assign job_ready_o = (st_q == ST_IDLE) && !clr_q;
  assign take = job_valid_i && job_ready_o;
  assign out_valid_o = (st_q == ST_OUT);
  assign flag_o = flag_q;
  assign join_stamp_o = when_q;

  always_comb begin
    st_d = st_q;
    cur_d = cur_q; ra_d = ra_q; rb_d = rb_q;
    dep_d = dep_q; da_d = da_q; db_d = db_q;
    sza_d = sza_q; szb_d = szb_q; pa_d = pa_q; pb_d = pb_q;
    best_d = best_q; flag_d = flag_q; when_d = when_q;
    rd_addr = cur_q; rd_addr2 = pb_q;
    wr_en = 1'b0; wr_addr = rb_q; wr_par = ra_q; wr_jn = {1'b0, job_q.stamp};
    wr_siz_en = 1'b0; wr_siz_addr = ra_q;
    wr_siz = sza_q + szb_q + 1'b1;
    stop_v = 1'b0;
    case (st_q)
      ST_IDLE: if (take) begin
        cur_d = job_i.a;
        dep_d = '0;
        best_d = '0;
        flag_d = job_i.flag;
        when_d = '0;
        st_d = (job_i.kind == KIND_TRIVIAL) ? ST_OUT : ST_RD_A;
      end
      ST_RD_A, ST_RD_B: begin
        st_d = (st_q == ST_RD_A) ? ST_WT_A : ST_WT_B;
      end
      ST_WT_A, ST_WT_B: st_d = (st_q == ST_WT_A) ? ST_CL_A : ST_CL_B;
      ST_CL_A, ST_CL_B: begin
        stop_v = (par_v == cur_q) ||
                 (job_q.kind == KIND_CONN && jn_v > {1'b0, job_q.stamp});
        if (stop_v) begin
          if (st_q == ST_CL_A) begin
            ra_d = cur_q; sza_d = rsiz_q; da_d = dep_q;
            cur_d = job_q.b; dep_d = '0; st_d = ST_RD_B;
          end else begin
            rb_d = cur_q; szb_d = rsiz_q; db_d = dep_q;
            case (job_q.kind)
              KIND_UNITE: st_d = (ra_q == cur_q) ? ST_OUT : ST_UNITE;
              KIND_CONN: begin flag_d = (ra_q == cur_q); st_d = ST_OUT; end
              default: begin
                if (ra_q != cur_q) st_d = ST_OUT;
                else begin
                  flag_d = 1'b1; pa_d = job_q.a; pb_d = job_q.b;
                  st_d = ST_RD_P;
                end
              end
            endcase
          end
        end else begin
          cur_d = par_v; dep_d = dep_q + 1'b1;
          st_d = (st_q == ST_CL_A) ? ST_RD_A : ST_RD_B;
        end
      end
      ST_UNITE: begin
        if (sza_q < szb_q) begin
          ra_d = rb_q; rb_d = ra_q; sza_d = szb_q; szb_d = sza_q;
        end
        st_d = ST_UPD;
      end
      ST_UPD: begin
        wr_en = 1'b1; wr_siz_en = 1'b1;
        flag_d = 1'b1; st_d = ST_OUT;
      end
      ST_RD_P: begin
        rd_addr = pa_q; rd_addr2 = pb_q; st_d = ST_WT_P;
      end
      ST_WT_P: begin
        rd_addr = pa_q; st_d = ST_PM;
      end
      ST_PM: begin
        if (pa_q == pb_q) begin
          when_d = best_q[TIME_BITS-1:0]; st_d = ST_OUT;
        end else begin
          if (da_q > db_q) begin
            if (jn_v > best_d) best_d = jn_v;
            pa_d = par_v; da_d = da_q - 1'b1;
          end else if (db_q > da_q) begin
            if (jn2_v > best_d) best_d = jn2_v;
            pb_d = par2_v; db_d = db_q - 1'b1;
          end else begin
            if (jn_v > best_d) best_d = jn_v;
            if (jn2_v > best_d) best_d = jn2_v;
            pa_d = par_v; pb_d = par2_v;
          end
          st_d = ST_RD_P;
        end
      end
      ST_OUT: if (out_ready_i) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (take) job_q <= job_i;
    cur_q <= cur_d; ra_q <= ra_d; rb_q <= rb_d;
    dep_q <= dep_d; da_q <= da_d; db_q <= db_d;
    sza_q <= sza_d; szb_q <= szb_d; pa_q <= pa_d; pb_q <= pb_d;
    best_q <= best_d; flag_q <= flag_d; when_q <= when_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      clr_q <= 1'b1;
      clr_cnt_q <= '0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= 1'b0;
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == (NODE_BITS+1)'(NODES-1)) clr_q <= 1'b0;
      end
    end
  end

  a_no_take_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !take) else $error("job during clear");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(flag_o))
    else $error("result dropped");
  a_write_only_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> st_q == ST_UPD && ra_q != rb_q) else $error("bad write");
  a_ov: assert property (@(posedge clk_i) disable iff (!rst_ni) !ov_q)
    else $error("overflow");
endmodule

@@ rtl/persistent_union_find.sv @@
// Union-find over 1024 nodes with union by size and per-node join stamps.
// A request climbs the parent chain of each node one level at a time
// (single registered memory read per level), then for an earliest-
// time query walks both paths to the common ancestor one step at a
// time; path depth is at most 10 under union by size.
// After reset a pass clears all 1024 entries before the first request
// is carried out. A two-entry queue sits between intake and execution.
module persistent_union_find (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    action_i,
  input  logic [puf_pkg::NODE_BITS-1:0] node_a_i,
  input  logic [puf_pkg::NODE_BITS-1:0] node_b_i,
  input  logic [puf_pkg::TIME_BITS-1:0] stamp_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          flag_o,
  output logic [puf_pkg::TIME_BITS-1:0] join_stamp_o
);
  import puf_pkg::*;

  job_t job;
  logic job_valid, job_ready;

  puf_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .action_i, .node_a_i,
    .node_b_i, .stamp_i, .job_valid_o(job_valid), .job_ready_i(job_ready),
    .job_o(job)
  );

  puf_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_ready_o(job_ready),
    .job_i(job), .out_valid_o, .out_ready_i, .flag_o, .join_stamp_o
  );
endmodule
